// ----- rtl/i2c_master_byte_engine_core_assert.svh -----
// Assertion macros for the I2C master engine (i2cm_engine.sv).
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2CM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("i2cm assertion failed");

// Next-cycle implication, checked outside reset.
`define I2CM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("i2cm assertion failed");

`endif

// ----- rtl/i2cm_pkg.sv -----
`default_nettype none

package i2cm_pkg;

    // Command codes carried in the operation field.
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_RESTART = 3'd1;
    localparam logic [2:0] OP_WRITE   = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd400;
    localparam logic [7:0]  MSB_MASK          = 8'h80;
    localparam logic [3:0]  BYTE_BITS         = 4'd8;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] operation;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       ready_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_ok;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/i2cm_in_stage.sv -----
`default_nettype none

module i2cm_in_stage import i2cm_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          q_valid,
    input  wire logic     q_ready,
    output in_item_t      q_data
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    // The register frees up in the same cycle that the engine takes its request.
    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/i2cm_engine.sv -----
`default_nettype none

`include "i2c_master_byte_engine_core_assert.svh"

module i2cm_engine import i2cm_pkg::*; #(
    parameter int PHASE_COUNTER_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    localparam logic [3:0] PS_IDLE         = 4'd0;
    localparam logic [3:0] PS_START_HOLD   = 4'd1;
    localparam logic [3:0] PS_RESTART_LOW  = 4'd2;
    localparam logic [3:0] PS_RESTART_HIGH = 4'd3;
    localparam logic [3:0] PS_BIT_LOW      = 4'd4;
    localparam logic [3:0] PS_BIT_HIGH     = 4'd5;
    localparam logic [3:0] PS_ACK_LOW      = 4'd6;
    localparam logic [3:0] PS_ACK_HIGH     = 4'd7;
    localparam logic [3:0] PS_STOP_LOW     = 4'd8;
    localparam logic [3:0] PS_STOP_CLK     = 4'd9;
    localparam logic [3:0] PS_STOP_RELEASE = 4'd10;

    localparam logic [31:0] PHASE_MAX = 32'((64'd1 << PHASE_COUNTER_BITS) - 64'd1);

    logic [15:0]                   half_period_reg;
    logic [3:0]                    phase_reg, phase_next;
    logic [2:0]                    op_reg, op_next;
    logic [3:0]                    bit_idx_reg, bit_idx_next;
    logic [7:0]                    shift_reg, shift_next;
    logic                          nack_reg, nack_next;
    logic [PHASE_COUNTER_BITS-1:0] timer_reg, timer_next;
    logic                          scl_reg, scl_next;
    logic                          sda_reg, sda_next;
    logic [7:0]                    rx_reg, rx_next;
    logic                          ack_reg, ack_next;
    logic                          m_valid_reg, m_valid_next;
    out_item_t                     m_data_reg, m_data_next;

    logic                          step;
    logic                          idle_now;
    logic                          is_read;
    logic                          done;
    logic [15:0]                   load16;
    logic [31:0]                   load32;
    logic [PHASE_COUNTER_BITS-1:0] phase_load;
    logic [3:0]                    bit_idx_inc;
    logic [7:0]                    shifted;

    assign in_ready = !m_valid_reg || m_ready;
    assign step     = in_valid && in_ready;

    // Phase length less one, with zero treated as one and clipped to the counter range.
    always_comb begin
        load16     = (half_period_reg == 16'd0) ? 16'd0 : half_period_reg - 16'd1;
        load32     = {16'd0, load16};
        phase_load = (load32 > PHASE_MAX) ? PHASE_MAX[PHASE_COUNTER_BITS-1:0]
                                          : load32[PHASE_COUNTER_BITS-1:0];
    end

    assign idle_now    = (phase_reg == PS_IDLE) || (phase_reg > PS_STOP_RELEASE);
    assign is_read     = (op_reg == OP_READ);
    assign bit_idx_inc = bit_idx_reg + 4'd1;
    assign shifted     = {shift_reg[6:0], is_read ? in_data.sda_in : 1'b0};

    always_comb begin
        phase_next   = phase_reg;
        op_next      = op_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        nack_next    = nack_reg;
        timer_next   = timer_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rx_next      = rx_reg;
        ack_next     = ack_reg;
        done         = 1'b0;

        if (idle_now) begin
            phase_next = PS_IDLE;
            if (in_data.cmd_valid) begin
                unique case (in_data.operation)
                    OP_START: begin
                        shift_next = in_data.tx_byte;
                        op_next    = OP_START;
                        phase_next = PS_START_HOLD;
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                        timer_next = phase_load;
                    end
                    OP_RESTART: begin
                        shift_next = in_data.tx_byte;
                        op_next    = OP_RESTART;
                        phase_next = PS_RESTART_LOW;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        timer_next = phase_load;
                    end
                    OP_WRITE: begin
                        shift_next   = in_data.tx_byte;
                        op_next      = OP_WRITE;
                        bit_idx_next = 4'd0;
                        phase_next   = PS_BIT_LOW;
                        scl_next     = 1'b0;
                        sda_next     = |(in_data.tx_byte & MSB_MASK);
                        timer_next   = phase_load;
                    end
                    OP_READ: begin
                        shift_next   = 8'd0;
                        op_next      = OP_READ;
                        nack_next    = in_data.send_nack;
                        bit_idx_next = 4'd0;
                        phase_next   = PS_BIT_LOW;
                        scl_next     = 1'b0;
                        sda_next     = 1'b1;
                        timer_next   = phase_load;
                    end
                    OP_STOP: begin
                        op_next    = OP_STOP;
                        phase_next = PS_STOP_LOW;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        timer_next = phase_load;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (timer_reg != '0) begin
            timer_next = timer_reg - PHASE_COUNTER_BITS'(1);
        end else begin
            timer_next = phase_load;
            unique case (phase_reg)
                PS_START_HOLD: begin
                    bit_idx_next = 4'd0;
                    phase_next   = PS_BIT_LOW;
                    scl_next     = 1'b0;
                    sda_next     = |(shift_reg & MSB_MASK);
                end
                PS_RESTART_LOW: begin
                    phase_next = PS_RESTART_HIGH;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                PS_RESTART_HIGH: begin
                    phase_next = PS_START_HOLD;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                end
                PS_BIT_LOW: begin
                    phase_next = PS_BIT_HIGH;
                    scl_next   = 1'b1;
                end
                PS_BIT_HIGH: begin
                    shift_next   = shifted;
                    bit_idx_next = bit_idx_inc;
                    scl_next     = 1'b0;
                    if (bit_idx_inc >= BYTE_BITS) begin
                        phase_next = PS_ACK_LOW;
                        sda_next   = is_read ? nack_reg : 1'b1;
                    end else begin
                        phase_next = PS_BIT_LOW;
                        sda_next   = is_read ? 1'b1 : |(shifted & MSB_MASK);
                    end
                end
                PS_ACK_LOW: begin
                    phase_next = PS_ACK_HIGH;
                    scl_next   = 1'b1;
                end
                PS_ACK_HIGH: begin
                    // The timer keeps its value here; the bus is parked with both lines low.
                    timer_next = timer_reg;
                    if (is_read) begin
                        rx_next = shift_reg;
                    end else begin
                        ack_next = !in_data.sda_in;
                    end
                    phase_next = PS_IDLE;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    done       = 1'b1;
                end
                PS_STOP_LOW: begin
                    phase_next = PS_STOP_CLK;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                end
                PS_STOP_CLK: begin
                    phase_next = PS_STOP_RELEASE;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                default: begin
                    timer_next = timer_reg;
                    phase_next = PS_IDLE;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    done       = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        m_data_next.scl_out   = scl_next;
        m_data_next.sda_out   = sda_next;
        m_data_next.ready_res = (phase_next == PS_IDLE);
        m_data_next.done_res  = done;
        m_data_next.rx_byte   = rx_next;
        m_data_next.ack_ok    = ack_next;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (cfg_wr_en) begin
            half_period_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PS_IDLE;
            op_reg      <= 3'd0;
            bit_idx_reg <= 4'd0;
            shift_reg   <= 8'd0;
            nack_reg    <= 1'b0;
            timer_reg   <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            rx_reg      <= 8'd0;
            ack_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (step) begin
                phase_reg   <= phase_next;
                op_reg      <= op_next;
                bit_idx_reg <= bit_idx_next;
                shift_reg   <= shift_next;
                nack_reg    <= nack_next;
                timer_reg   <= timer_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                rx_reg      <= rx_next;
                ack_reg     <= ack_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `I2CM_ASSERT_IMP(a_done_is_ready, aclk, aresetn,
        m_valid_reg && m_data_reg.done_res, m_data_reg.ready_res)
    `I2CM_ASSERT_NEXT(a_ready_tracks_phase, aclk, aresetn,
        step, m_data_reg.ready_res == (phase_reg == PS_IDLE))
    `I2CM_ASSERT_NEXT(a_phase_holds_while_timing, aclk, aresetn,
        step && !idle_now && (timer_reg != '0), phase_reg == $past(phase_reg))
    `I2CM_ASSERT_NEXT(a_stop_releases_bus, aclk, aresetn,
        step && (phase_reg == PS_STOP_RELEASE) && (timer_reg == '0),
        m_data_reg.scl_out && m_data_reg.sda_out && m_data_reg.done_res)

endmodule

`default_nettype wire

// ----- rtl/i2c_master_byte_engine_core.sv -----
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_data  (in_item_t: one engine step)
// m_        out        m_valid / m_ready  m_data  (out_item_t: levels after that step)
// cfg_      in         cfg_wr_en          cfg_wr_data (half period in steps)
//
// Every request gives exactly one result; one request is taken per cycle when the
// result side keeps up. A request is loaded into the input register when accepted
// and then stepped by the engine into the result register, where it shows as valid.
// A stalled result holds its register and the input register; s_ready falls once the
// input register is full.
// Reset is synchronous and active low: the bus is released and the engine is idle.
`default_nettype none

module i2c_master_byte_engine_core import i2cm_pkg::*; #(
    parameter int PHASE_COUNTER_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    logic     q_valid;
    logic     q_ready;
    in_item_t q_data;

    i2cm_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    i2cm_engine #(
        .PHASE_COUNTER_BITS (PHASE_COUNTER_BITS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_data     (q_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// ----- tb/tb_i2c_master_byte_engine_core.sv -----
`timescale 1ns / 1ps

import i2cm_pkg::*;

typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_HOLD,
    PH_RESTART_LOW,
    PH_RESTART_HIGH,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_ACK_LOW,
    PH_ACK_HIGH,
    PH_STOP_LOW,
    PH_STOP_CLK,
    PH_STOP_RELEASE
} bus_phase_t;

// Tracks the engine's bus state request by request and holds the line levels
// that each request should produce, oldest first.
class bus_level_tracker;
    logic [15:0] half_period;
    bus_phase_t  phase;
    logic [2:0]  cur_op;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic        nack_bit;
    logic [15:0] phase_left;
    logic        scl;
    logic        sda;
    logic [7:0]  rx_last;
    logic        ack_last;
    out_item_t   pending_levels[$];
    int          mismatches;

    function new();
        half_period = HALF_PERIOD_RESET;
        phase       = PH_IDLE;
        cur_op      = '0;
        bit_cnt     = '0;
        shreg       = '0;
        nack_bit    = 1'b0;
        phase_left  = '0;
        scl         = 1'b1;
        sda         = 1'b1;
        rx_last     = '0;
        ack_last    = 1'b0;
        mismatches  = 0;
    endfunction

    function bit engine_idle();
        return phase == PH_IDLE;
    endfunction

    function int pending();
        return pending_levels.size();
    endfunction

    // A zero half period behaves as a half period of one.
    function void enter(bus_phase_t nxt, logic c, logic d);
        phase      = nxt;
        scl        = c;
        sda        = d;
        phase_left = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;
    endfunction

    function void note_request(in_item_t req);
        out_item_t res;
        logic      done;
        logic      rd;
        done = 1'b0;
        rd   = (cur_op == OP_READ);
        if (phase == PH_IDLE) begin
            if (req.cmd_valid) begin
                unique case (req.operation)
                    OP_START: begin
                        shreg  = req.tx_byte;
                        cur_op = OP_START;
                        enter(PH_START_HOLD, 1'b1, 1'b0);
                    end
                    OP_RESTART: begin
                        shreg  = req.tx_byte;
                        cur_op = OP_RESTART;
                        enter(PH_RESTART_LOW, 1'b0, 1'b1);
                    end
                    OP_WRITE: begin
                        shreg   = req.tx_byte;
                        cur_op  = OP_WRITE;
                        bit_cnt = '0;
                        enter(PH_BIT_LOW, 1'b0, shreg[7]);
                    end
                    OP_READ: begin
                        shreg    = '0;
                        cur_op   = OP_READ;
                        nack_bit = req.send_nack;
                        bit_cnt  = '0;
                        enter(PH_BIT_LOW, 1'b0, 1'b1);
                    end
                    OP_STOP: begin
                        cur_op = OP_STOP;
                        enter(PH_STOP_LOW, 1'b0, 1'b0);
                    end
                    default: ;
                endcase
            end
        end else if (phase_left != 16'd0) begin
            phase_left = phase_left - 16'd1;
        end else begin
            unique case (phase)
                PH_START_HOLD: begin
                    bit_cnt = '0;
                    enter(PH_BIT_LOW, 1'b0, shreg[7]);
                end
                PH_RESTART_LOW:  enter(PH_RESTART_HIGH, 1'b1, 1'b1);
                PH_RESTART_HIGH: enter(PH_START_HOLD, 1'b1, 1'b0);
                PH_BIT_LOW:      enter(PH_BIT_HIGH, 1'b1, sda);
                PH_BIT_HIGH: begin
                    shreg   = {shreg[6:0], rd ? req.sda_in : 1'b0};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= BYTE_BITS)
                        enter(PH_ACK_LOW, 1'b0, rd ? nack_bit : 1'b1);
                    else
                        enter(PH_BIT_LOW, 1'b0, rd ? 1'b1 : shreg[7]);
                end
                PH_ACK_LOW: enter(PH_ACK_HIGH, 1'b1, sda);
                PH_ACK_HIGH: begin
                    if (rd)
                        rx_last = shreg;
                    else
                        ack_last = (req.sda_in == 1'b0);
                    phase = PH_IDLE;
                    scl   = 1'b0;
                    sda   = 1'b0;
                    done  = 1'b1;
                end
                PH_STOP_LOW: enter(PH_STOP_CLK, 1'b1, 1'b0);
                PH_STOP_CLK: enter(PH_STOP_RELEASE, 1'b1, 1'b1);
                default: begin
                    phase = PH_IDLE;
                    scl   = 1'b1;
                    sda   = 1'b1;
                    done  = 1'b1;
                end
            endcase
        end
        res.scl_out   = scl;
        res.sda_out   = sda;
        res.ready_res = (phase == PH_IDLE);
        res.done_res  = done;
        res.rx_byte   = rx_last;
        res.ack_ok    = ack_last;
        pending_levels.push_back(res);
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatches++;
        $display("tb: mismatch in %s: got %0h, want %0h", what, got, want);
    endtask

    task check_levels(out_item_t got);
        out_item_t want;
        if (pending_levels.size() == 0) begin
            report_mismatch("result with nothing outstanding", got.rx_byte, 8'h00);
        end else begin
            want = pending_levels.pop_front();
            if (got.scl_out !== want.scl_out)
                report_mismatch("scl_out", {7'd0, got.scl_out}, {7'd0, want.scl_out});
            if (got.sda_out !== want.sda_out)
                report_mismatch("sda_out", {7'd0, got.sda_out}, {7'd0, want.sda_out});
            if (got.ready_res !== want.ready_res)
                report_mismatch("ready_res", {7'd0, got.ready_res},
                                {7'd0, want.ready_res});
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", {7'd0, got.done_res}, {7'd0, want.done_res});
            if (got.rx_byte !== want.rx_byte)
                report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
            if (got.ack_ok !== want.ack_ok)
                report_mismatch("ack_ok", {7'd0, got.ack_ok}, {7'd0, want.ack_ok});
        end
    endtask
endclass

module tb_i2c_master_byte_engine_core;

    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_MID_UNUSED   = 3'd6;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
    localparam int         CYCLE_LIMIT     = 1000000;
    localparam int         RANDOM_ITEMS    = 220;

    typedef struct {
        logic [2:0] op;
        logic [7:0] tx;
        logic       nack;
    } bus_cmd_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_item_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_item_t   m_data;

    bus_level_tracker levels = new();
    bus_cmd_t         cmd_plan[$];
    int               idle_pct   = 0;
    int               stall_pct  = 0;
    int               cycle_count = 0;

    i2c_master_byte_engine_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            levels.check_levels(m_data);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void add_cmd(logic [2:0] op, logic [7:0] tx, logic nack);
        bus_cmd_t c;
        c.op   = op;
        c.tx   = tx;
        c.nack = nack;
        cmd_plan.push_back(c);
    endfunction

    // Mostly well-formed transfers: start, one to three data bytes, an optional repeated
    // start with reads, then a stop in most cases. Now and then a lone command of any kind.
    function automatic void plan_sequence();
        int k;
        if ($urandom_range(99) < 15) begin
            add_cmd(3'($urandom_range(4)), 8'($urandom), 1'($urandom));
            return;
        end
        add_cmd(OP_START, 8'($urandom), 1'b0);
        k = $urandom_range(3, 1);
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(1) == 0)
                add_cmd(OP_WRITE, 8'($urandom), 1'($urandom));
            else
                add_cmd(OP_READ, 8'($urandom), (i == k - 1) ? 1'b1 : 1'($urandom));
        end
        if ($urandom_range(99) < 30) begin
            add_cmd(OP_RESTART, 8'($urandom), 1'b0);
            k = $urandom_range(2, 1);
            for (int i = 0; i < k; i++)
                add_cmd(OP_READ, 8'($urandom), i == k - 1);
        end
        if ($urandom_range(99) < 90)
            add_cmd(OP_STOP, 8'($urandom), 1'($urandom));
    endfunction

    function automatic in_item_t pick_request(bit cmds_on, bit may_refill);
        in_item_t r;
        bus_cmd_t c;
        r.cmd_valid = 1'b0;
        r.operation = 3'($urandom_range(7));
        r.tx_byte   = 8'($urandom);
        r.send_nack = 1'($urandom);
        r.sda_in    = 1'($urandom);
        if (!cmds_on) begin
            r.cmd_valid = 1'($urandom);
            r.operation = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
        end else if (!levels.engine_idle()) begin
            // Commands offered while the engine is busy should be dropped.
            r.cmd_valid = ($urandom_range(9) == 0);
        end else begin
            if (cmd_plan.size() == 0 && may_refill)
                plan_sequence();
            if (cmd_plan.size() != 0 && $urandom_range(3) != 0) begin
                c = cmd_plan.pop_front();
                r.cmd_valid = 1'b1;
                r.operation = c.op;
                r.tx_byte   = c.tx;
                r.send_nack = c.nack;
            end else if ($urandom_range(15) == 0) begin
                r.cmd_valid = 1'b1;
                r.operation = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
            end
        end
        return r;
    endfunction

    // Offers requests until n_items have gone in, then carries on without planning new
    // commands until the planned ones are used up and the engine is idle again.
    task automatic run_bus(int n_items, bit cmds_on);
        in_item_t req;
        bit       holding;
        bit       fin;
        int       sent;
        req     = '0;
        holding = 1'b0;
        fin     = 1'b0;
        sent    = 0;
        while (!fin) begin
            @(posedge aclk);
            if (s_valid && s_ready) begin
                levels.note_request(s_data);
                sent++;
                holding = 1'b0;
            end
            if (!holding && sent >= n_items && cmd_plan.size() == 0 && levels.engine_idle())
                fin = 1'b1;
            else if (!holding && $urandom_range(99) >= idle_pct) begin
                req     = pick_request(cmds_on, sent < n_items);
                holding = 1'b1;
            end
            s_valid <= holding;
            s_data  <= req;
        end
    endtask

    task automatic set_half_period(logic [15:0] value);
        while (levels.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        levels.half_period = value;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset levels and dropped unused codes at the default half period.
        run_bus(20, 1'b0);

        set_half_period(16'd1);
        add_cmd(OP_START, 8'h00, 1'b0);
        add_cmd(OP_WRITE, 8'hFF, 1'b0);
        add_cmd(OP_WRITE, 8'h80, 1'b1);
        add_cmd(OP_READ, 8'h00, 1'b0);
        add_cmd(OP_READ, 8'hFF, 1'b1);
        add_cmd(OP_FIRST_UNUSED, 8'hFF, 1'b1);
        add_cmd(OP_RESTART, 8'hFF, 1'b0);
        add_cmd(OP_WRITE, 8'h01, 1'b0);
        // A start while the bus is still held low after a byte.
        add_cmd(OP_START, 8'hA5, 1'b0);
        add_cmd(OP_READ, 8'h5A, 1'b1);
        add_cmd(OP_STOP, 8'h00, 1'b0);
        add_cmd(OP_STOP, 8'hFF, 1'b1);
        add_cmd(OP_MID_UNUSED, 8'h00, 1'b0);
        add_cmd(OP_WRITE, 8'h55, 1'b0);
        add_cmd(OP_READ, 8'hAA, 1'b0);
        add_cmd(OP_LAST_UNUSED, 8'h00, 1'b0);
        add_cmd(OP_STOP, 8'h00, 1'b0);
        run_bus(0, 1'b1);

        // A zero half period must behave as a half period of one.
        set_half_period(16'd0);
        add_cmd(OP_START, 8'h3C, 1'b0);
        add_cmd(OP_READ, 8'hC3, 1'b1);
        add_cmd(OP_STOP, 8'h00, 1'b0);
        run_bus(0, 1'b1);

        set_half_period(16'hFFFF);
        run_bus(30, 1'b0);

        set_half_period(16'd1);
        run_bus(RANDOM_ITEMS, 1'b1);

        set_half_period(16'd2);
        idle_pct = 75;
        run_bus(RANDOM_ITEMS, 1'b1);

        set_half_period(16'd3);
        idle_pct  = 0;
        stall_pct = 75;
        run_bus(RANDOM_ITEMS, 1'b1);

        set_half_period(16'd1);
        idle_pct  = 16;
        stall_pct = 16;
        run_bus(RANDOM_ITEMS, 1'b1);

        while (levels.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (levels.mismatches == 0 && levels.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- i2c_master_byte_engine_core.f -----
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_in_stage.sv
rtl/i2cm_engine.sv
rtl/i2c_master_byte_engine_core.sv
tb/tb_i2c_master_byte_engine_core.sv
